### hdl/ascon_pkg.sv
package ascon_pkg;

  typedef logic [4:0][63:0] state_t;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_AD     = 2'd1;
  localparam logic [1:0] OP_CT     = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_AD   = 2'd1;
  localparam logic [1:0] PH_CT   = 2'd2;
  localparam logic [1:0] PH_TAG  = 2'd3;

  localparam logic [63:0] ASCON_IV  = 64'h80400c0600000000;
  localparam logic [63:0] PAD_FIRST = 64'h8000000000000000;
  localparam logic [63:0] DOMAIN_SEP = 64'h0000000000000001;

  localparam logic [3:0] RND_FIRST_FULL = 4'd0;
  localparam logic [3:0] RND_FIRST_AD   = 4'd6;
  localparam logic [3:0] RND_LAST       = 4'd11;

  function automatic logic [7:0] round_const(input logic [3:0] r);
    logic [7:0] c;
    case (r)
      4'd0:    c = 8'hf0;
      4'd1:    c = 8'he1;
      4'd2:    c = 8'hd2;
      4'd3:    c = 8'hc3;
      4'd4:    c = 8'hb4;
      4'd5:    c = 8'ha5;
      4'd6:    c = 8'h96;
      4'd7:    c = 8'h87;
      4'd8:    c = 8'h78;
      4'd9:    c = 8'h69;
      4'd10:   c = 8'h5a;
      4'd11:   c = 8'h4b;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // top 4*n bits set
  function automatic logic [63:0] nib_mask(input logic [3:0] n);
    return ~({64{1'b1}} >> {n, 2'b00});
  endfunction

  // single bit just after n nibbles
  function automatic logic [63:0] pad_bit(input logic [3:0] n);
    return PAD_FIRST >> {n, 2'b00};
  endfunction

endpackage

### hdl/ascon_if.sv
interface ascon_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] block_data;
  logic [63:0] extra_word;
  logic [4:0]  valid_nibbles;
  logic        last_block;

  modport source (output valid, op, block_data, extra_word, valid_nibbles, last_block,
                  input ready);
  modport sink   (input valid, op, block_data, extra_word, valid_nibbles, last_block,
                  output ready);
endinterface

interface ascon_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [63:0] plain_block;
  logic [4:0]  plain_nibbles;
  logic        tag_match;

  modport source (output valid, result_kind, plain_block, plain_nibbles, tag_match,
                  input ready);
  modport sink   (input valid, result_kind, plain_block, plain_nibbles, tag_match,
                  output ready);
endinterface

### hdl/ascon_round.sv
module ascon_round
  import ascon_pkg::*;
(
  input  state_t     s,
  input  logic [7:0] rc,
  output state_t     s_out
);

  state_t x;
  state_t t;

  always_comb begin
    x = s;
    x[2] = x[2] ^ {56'd0, rc};
    x[0] = x[0] ^ x[4];
    x[4] = x[4] ^ x[3];
    x[2] = x[2] ^ x[1];
    t[0] = ~x[0] & x[1];
    t[1] = ~x[1] & x[2];
    t[2] = ~x[2] & x[3];
    t[3] = ~x[3] & x[4];
    t[4] = ~x[4] & x[0];
    x[0] = x[0] ^ t[1];
    x[1] = x[1] ^ t[2];
    x[2] = x[2] ^ t[3];
    x[3] = x[3] ^ t[4];
    x[4] = x[4] ^ t[0];
    x[1] = x[1] ^ x[0];
    x[0] = x[0] ^ x[4];
    x[3] = x[3] ^ x[2];
    x[2] = ~x[2];
    s_out[0] = x[0] ^ {x[0][18:0], x[0][63:19]} ^ {x[0][27:0], x[0][63:28]};
    s_out[1] = x[1] ^ {x[1][60:0], x[1][63:61]} ^ {x[1][38:0], x[1][63:39]};
    s_out[2] = x[2] ^ {x[2][0],    x[2][63:1]}  ^ {x[2][5:0],  x[2][63:6]};
    s_out[3] = x[3] ^ {x[3][9:0],  x[3][63:10]} ^ {x[3][16:0], x[3][63:17]};
    s_out[4] = x[4] ^ {x[4][6:0],  x[4][63:7]}  ^ {x[4][40:0], x[4][63:41]};
  end

endmodule

### hdl/ascon128_verified_decrypt.sv
// Channel  Role    Payload
// cfg      write   cfg_we, cfg_index (0 key_high, 1 key_low), cfg_data
// req      sink    op, block_data, extra_word, valid_nibbles, last_block
// rsp      source  result_kind, plain_block, plain_nibbles, tag_match
//
// One permutation round per cycle through a single shared round unit.
// Begin: full permutation; associated data: reduced, plus a padding pass for a full
// last block; ciphertext: reduced for a full block, none for a partial last block;
// finish: full (none when idle). Ignored items have no effect; req is not ready while
// an item is in progress. A result waits in the rsp register; the next item is taken
// meanwhile. rst is synchronous, active high; it clears keys, state and phase.
module ascon128_verified_decrypt
  import ascon_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  ascon_req_if.sink   req,
  ascon_rsp_if.source rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PERM = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]   st, st_next;
  logic [1:0]   phase, phase_next;
  state_t       s, s_next, perm_out;
  logic [3:0]   rnd, rnd_next;
  logic [1:0]   op_r, op_next;
  logic         last_r, last_next;
  logic         second, second_next;
  logic [127:0] tag, tag_next;
  logic [63:0]  key_high, key_low;

  logic         res_kind, res_kind_next;
  logic [63:0]  res_plain, res_plain_next;
  logic [4:0]   res_nib, res_nib_next;
  logic         res_match, res_match_next;

  logic         out_valid, out_valid_next;
  logic         out_kind, out_kind_next;
  logic [63:0]  out_plain, out_plain_next;
  logic [4:0]   out_nib, out_nib_next;
  logic         out_match, out_match_next;

  logic [4:0]   nib;
  logic         full;
  logic [63:0]  ct_mix;

  ascon_round u_round (
    .s     (s),
    .rc    (round_const(rnd)),
    .s_out (perm_out)
  );

  assign req.ready         = (st == ST_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.result_kind   = out_kind;
  assign rsp.plain_block   = out_plain;
  assign rsp.plain_nibbles = out_nib;
  assign rsp.tag_match     = out_match;

  always_comb begin
    if (!req.last_block || req.valid_nibbles > 5'd16) begin
      nib = 5'd16;
    end else begin
      nib = req.valid_nibbles;
    end
    full   = nib[4];
    ct_mix = s[0] ^ req.block_data;
  end

  always_comb begin
    st_next        = st;
    phase_next     = phase;
    s_next         = s;
    rnd_next       = rnd;
    op_next        = op_r;
    last_next      = last_r;
    second_next    = second;
    tag_next       = tag;
    res_kind_next  = res_kind;
    res_plain_next = res_plain;
    res_nib_next   = res_nib;
    res_match_next = res_match;
    out_valid_next = out_valid && !rsp.ready;
    out_kind_next  = out_kind;
    out_plain_next = out_plain;
    out_nib_next   = out_nib;
    out_match_next = out_match;

    unique case (st)
      ST_IDLE: begin
        if (req.valid) begin
          op_next   = req.op;
          last_next = req.last_block;
          case (req.op)
            OP_BEGIN: begin
              s_next[0] = ASCON_IV;
              s_next[1] = key_high;
              s_next[2] = key_low;
              s_next[3] = req.block_data;
              s_next[4] = req.extra_word;
              rnd_next  = RND_FIRST_FULL;
              st_next   = ST_PERM;
            end
            OP_AD: begin
              if (phase == PH_AD) begin
                if (full) begin
                  s_next[0] = s[0] ^ req.block_data;
                end else begin
                  s_next[0] = s[0] ^ ((req.block_data & nib_mask(nib[3:0]))
                              | pad_bit(nib[3:0]));
                end
                second_next = full && req.last_block;
                rnd_next    = RND_FIRST_AD;
                st_next     = ST_PERM;
              end
            end
            OP_CT: begin
              if (phase == PH_AD || phase == PH_CT) begin
                if (phase == PH_AD) begin
                  s_next[4] = s[4] ^ DOMAIN_SEP;
                end
                res_kind_next  = 1'b0;
                res_nib_next   = nib;
                res_match_next = 1'b0;
                if (full) begin
                  res_plain_next = ct_mix;
                  s_next[0]      = req.block_data;
                  rnd_next       = RND_FIRST_AD;
                  phase_next     = PH_CT;
                  st_next        = ST_PERM;
                end else begin
                  res_plain_next = ct_mix & nib_mask(nib[3:0]);
                  s_next[0]      = s[0] ^ (ct_mix & nib_mask(nib[3:0]))
                                   ^ pad_bit(nib[3:0]);
                  phase_next     = PH_TAG;
                  st_next        = ST_DONE;
                end
              end
            end
            default: begin
              res_kind_next  = 1'b1;
              res_plain_next = 64'd0;
              res_nib_next   = 5'd0;
              res_match_next = 1'b0;
              if (phase == PH_IDLE) begin
                st_next = ST_DONE;
              end else begin
                if (phase == PH_AD) begin
                  s_next[4] = s[4] ^ DOMAIN_SEP;
                end
                if (phase != PH_TAG) begin
                  s_next[0] = s[0] ^ PAD_FIRST;
                end
                s_next[1] = s[1] ^ key_high;
                s_next[2] = s[2] ^ key_low;
                tag_next  = {req.block_data, req.extra_word};
                rnd_next  = RND_FIRST_FULL;
                st_next   = ST_PERM;
              end
            end
          endcase
        end
      end
      ST_PERM: begin
        s_next   = perm_out;
        rnd_next = rnd + 4'd1;
        if (rnd == RND_LAST) begin
          st_next = ST_IDLE;
          case (op_r)
            OP_BEGIN: begin
              s_next[3]  = perm_out[3] ^ key_high;
              s_next[4]  = perm_out[4] ^ key_low;
              phase_next = PH_AD;
            end
            OP_AD: begin
              if (second) begin
                s_next[0]   = perm_out[0] ^ PAD_FIRST;
                second_next = 1'b0;
                rnd_next    = RND_FIRST_AD;
                st_next     = ST_PERM;
              end else if (last_r) begin
                s_next[4]  = perm_out[4] ^ DOMAIN_SEP;
                phase_next = PH_CT;
              end
            end
            OP_CT: begin
              if (last_r) begin
                s_next[0]  = perm_out[0] ^ PAD_FIRST;
                phase_next = PH_TAG;
              end
              st_next = ST_DONE;
            end
            default: begin
              res_match_next = ((perm_out[3] ^ key_high) == tag[127:64])
                            && ((perm_out[4] ^ key_low) == tag[63:0]);
              phase_next = PH_IDLE;
              st_next    = ST_DONE;
            end
          endcase
        end
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_kind_next  = res_kind;
          out_plain_next = res_plain;
          out_nib_next   = res_nib;
          out_match_next = res_match;
          st_next        = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      phase     <= PH_IDLE;
      s         <= '0;
      second    <= 1'b0;
      out_valid <= 1'b0;
      key_high  <= 64'd0;
      key_low   <= 64'd0;
    end else begin
      st        <= st_next;
      phase     <= phase_next;
      s         <= s_next;
      second    <= second_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        if (cfg_index) begin
          key_low <= cfg_data;
        end else begin
          key_high <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rnd       <= rnd_next;
    op_r      <= op_next;
    last_r    <= last_next;
    tag       <= tag_next;
    res_kind  <= res_kind_next;
    res_plain <= res_plain_next;
    res_nib   <= res_nib_next;
    res_match <= res_match_next;
    out_kind  <= out_kind_next;
    out_plain <= out_plain_next;
    out_nib   <= out_nib_next;
    out_match <= out_match_next;
  end

`ifndef SYNTHESIS
  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    (st == ST_PERM) |-> (rnd <= RND_LAST))
    else $error("round counter out of range");

  a_begin_runs: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.op == OP_BEGIN) |=> (st == ST_PERM && rnd == RND_FIRST_FULL))
    else $error("begin did not start a full permutation");

  a_plain_no_match: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.result_kind) |-> !rsp.tag_match)
    else $error("plaintext transaction carries a tag match");

  a_verdict_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.result_kind) |-> (rsp.plain_block == 64'd0 && rsp.plain_nibbles == 5'd0))
    else $error("verdict transaction carries plaintext");

  a_second_pass_ad: assert property (@(posedge clk) disable iff (rst)
    second |-> (st == ST_PERM && op_r == OP_AD))
    else $error("padding pass pending outside associated data");
`endif

endmodule
